// ===== src/sparse_triplet_matrix_add_top_defines.svh =====
// Assertion macros for the sparse triplet matrix adder.
// Included by modules that carry concurrent checks; expects clk_i and rst_ni in scope.
`ifndef SPARSE_TRIPLET_MATRIX_ADD_TOP_DEFINES_SVH
`define SPARSE_TRIPLET_MATRIX_ADD_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define STMA_ASSERT_HOLDS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("stma: same-cycle check failed");

// Next-cycle implication, disabled while in reset
`define STMA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("stma: next-cycle check failed");

`endif

// ===== src/stma_pkg.sv =====
// Shared types and constants for the sparse triplet matrix adder.
// No dependencies; imported by stma_store and the top level.
package stma_pkg;

  // Field widths
  localparam int KIND_W    = 2;
  localparam int ROW_W     = 8;
  localparam int COL_W     = 8;
  localparam int VAL_W     = 16;
  localparam int SUM_W     = VAL_W + 1;
  localparam int CNT_OUT_W = 7;
  localparam int KEY_W     = ROW_W + COL_W;
  localparam int WORD_W    = KEY_W + VAL_W;

  // Default store depth
  localparam int DEPTH_DEF = 32;

  // Stream widths
  localparam int S_TDATA_W = 32;
  localparam int S_TUSER_W = KIND_W;
  localparam int M_TDATA_W = 40;

  // Item kinds carried in the input tuser
  localparam logic [KIND_W-1:0] KIND_LOAD_A = KIND_W'(0);
  localparam logic [KIND_W-1:0] KIND_LOAD_B = KIND_W'(1);
  localparam logic [KIND_W-1:0] KIND_MERGE  = KIND_W'(2);

endpackage

// ===== src/stma_store.sv =====
// Entry store: one write port, one read port with registered read data.
// Depends on stma_pkg for the word width.
module stma_store #(
  parameter int DEPTH = stma_pkg::DEPTH_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                       clk_i,
  input  logic                       wr_en_i,
  input  logic [AW-1:0]              wr_addr_i,
  input  logic [stma_pkg::WORD_W-1:0] wr_data_i,
  input  logic [AW-1:0]              rd_addr_i,
  output logic [stma_pkg::WORD_W-1:0] rd_data_o
);
  import stma_pkg::*;

  logic [WORD_W-1:0] mem_q [DEPTH];
  logic [WORD_W-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== src/sparse_triplet_matrix_add_top.sv =====
// Sparse triplet matrix adder. Load transactions (tuser kind A or B) append one
// (row, col, value) entry to the matching store; loads beyond DEPTH entries are
// dropped. A merge transaction walks both row-major lists twice with one shared
// compare/add unit: a counting pass, then an emitting pass that sends each
// merged entry with the total count. Each merge step passes through a read
// state and a compare state, set by the registered read port of the stores,
// and the emitting pass waits on any output stall; the block takes no new
// transaction until the merge is finished. With both lists empty one result
// flagged empty is sent. After a merge both stores count as empty again.
// Depends on stma_pkg, stma_store and sparse_triplet_matrix_add_top_defines.svh.
`include "sparse_triplet_matrix_add_top_defines.svh"

module sparse_triplet_matrix_add_top #(
  parameter int DEPTH = stma_pkg::DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [7:0] row, [15:8] col, [31:16] value
  input  logic [stma_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  // [1:0] kind
  input  logic [stma_pkg::S_TUSER_W-1:0] s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [7:0] out_row, [15:8] out_col, [32:16] sum_value, [39:33] entry_count
  output logic [stma_pkg::M_TDATA_W-1:0] m_axis_tdata_o,
  output logic                          m_axis_tlast_o,
  // [0] empty_res
  output logic                          m_axis_tuser_o
);
  import stma_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int NW = $clog2(2 * DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP
  } state_e;

  state_e          state_q;
  logic            pass_emit_q;
  logic [CW-1:0]   a_cnt_q, b_cnt_q;
  logic [CW-1:0]   i_q, j_q;
  logic [NW-1:0]   n_q, k_q;

  logic              m_valid_q;
  logic [ROW_W-1:0]  out_row_q;
  logic [COL_W-1:0]  out_col_q;
  logic [SUM_W-1:0]  out_sum_q;
  logic              out_last_q;
  logic              out_empty_q;
  logic [CNT_OUT_W-1:0] out_cnt_q;

  // input unpacking
  logic              s_acc;
  logic [KIND_W-1:0] in_kind;
  logic [WORD_W-1:0] in_word;
  logic              a_wr, b_wr;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign in_kind = s_axis_tuser_i;
  assign in_word = {s_axis_tdata_i[7:0], s_axis_tdata_i[15:8], s_axis_tdata_i[31:16]};
  assign a_wr    = s_acc && (in_kind == KIND_LOAD_A) && (a_cnt_q < CW'(DEPTH));
  assign b_wr    = s_acc && (in_kind == KIND_LOAD_B) && (b_cnt_q < CW'(DEPTH));

  // entry stores
  logic [WORD_W-1:0] a_rd, b_rd;

  stma_store #(.DEPTH(DEPTH), .AW(AW)) u_a_store (
    .clk_i     (clk_i),
    .wr_en_i   (a_wr),
    .wr_addr_i (a_cnt_q[AW-1:0]),
    .wr_data_i (in_word),
    .rd_addr_i (i_q[AW-1:0]),
    .rd_data_o (a_rd)
  );

  stma_store #(.DEPTH(DEPTH), .AW(AW)) u_b_store (
    .clk_i     (clk_i),
    .wr_en_i   (b_wr),
    .wr_addr_i (b_cnt_q[AW-1:0]),
    .wr_data_i (in_word),
    .rd_addr_i (j_q[AW-1:0]),
    .rd_data_o (b_rd)
  );

  // shared compare/add unit for one merge step
  logic             a_av, b_av, take_a, take_b;
  logic [KEY_W-1:0] ka, kb, key;
  logic [SUM_W-1:0] va, vb, sum;

  assign a_av   = (i_q < a_cnt_q);
  assign b_av   = (j_q < b_cnt_q);
  assign ka     = a_rd[WORD_W-1:VAL_W];
  assign kb     = b_rd[WORD_W-1:VAL_W];
  assign take_a = a_av && (!b_av || (ka <= kb));
  assign take_b = b_av && (!a_av || (kb <= ka));
  assign va     = take_a ? {a_rd[VAL_W-1], a_rd[VAL_W-1:0]} : '0;
  assign vb     = take_b ? {b_rd[VAL_W-1], b_rd[VAL_W-1:0]} : '0;
  assign sum    = va + vb;
  assign key    = take_a ? ka : kb;

  logic out_free;
  assign out_free = !m_valid_q || m_axis_tready_i;

  // a result enters the output register this cycle
  logic out_load;
  assign out_load = (state_q == ST_CMP) && out_free &&
                    (pass_emit_q ? (a_av || b_av) : (!a_av && !b_av && (n_q == '0)));

  // sequencer, counters and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pass_emit_q <= 1'b0;
      a_cnt_q     <= '0;
      b_cnt_q     <= '0;
      i_q         <= '0;
      j_q         <= '0;
      n_q         <= '0;
      k_q         <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (a_wr) a_cnt_q <= a_cnt_q + CW'(1);
          if (b_wr) b_cnt_q <= b_cnt_q + CW'(1);
          if (s_acc && (in_kind == KIND_MERGE)) begin
            state_q     <= ST_READ;
            pass_emit_q <= 1'b0;
            i_q         <= '0;
            j_q         <= '0;
            n_q         <= '0;
            k_q         <= '0;
          end
        end
        ST_READ: begin
          state_q <= ST_CMP;
        end
        ST_CMP: begin
          if (!pass_emit_q) begin
            // counting pass
            if (!a_av && !b_av) begin
              if (n_q == '0) begin
                // both lists empty: one flagged result, then done
                if (out_free) begin
                  out_row_q   <= '0;
                  out_col_q   <= '0;
                  out_sum_q   <= '0;
                  out_last_q  <= 1'b1;
                  out_empty_q <= 1'b1;
                  out_cnt_q   <= '0;
                  a_cnt_q     <= '0;
                  b_cnt_q     <= '0;
                  state_q     <= ST_IDLE;
                end
              end else begin
                pass_emit_q <= 1'b1;
                i_q         <= '0;
                j_q         <= '0;
                state_q     <= ST_READ;
              end
            end else begin
              n_q     <= n_q + NW'(1);
              i_q     <= i_q + CW'(take_a);
              j_q     <= j_q + CW'(take_b);
              state_q <= ST_READ;
            end
          end else begin
            // emitting pass
            if (!a_av && !b_av) begin
              a_cnt_q <= '0;
              b_cnt_q <= '0;
              state_q <= ST_IDLE;
            end else if (out_free) begin
              out_row_q   <= key[KEY_W-1:COL_W];
              out_col_q   <= key[COL_W-1:0];
              out_sum_q   <= sum;
              out_last_q  <= ((k_q + NW'(1)) == n_q);
              out_empty_q <= 1'b0;
              out_cnt_q   <= CNT_OUT_W'(n_q);
              k_q         <= k_q + NW'(1);
              i_q         <= i_q + CW'(take_a);
              j_q         <= j_q + CW'(take_b);
              state_q     <= ST_READ;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {out_cnt_q, out_sum_q, out_col_q, out_row_q};
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_empty_q;

  // checks
  `STMA_ASSERT_HOLDS(a_idx_bound, state_q != ST_IDLE, (i_q <= a_cnt_q) && (j_q <= b_cnt_q))
  `STMA_ASSERT_HOLDS(a_emit_bound, pass_emit_q && (state_q != ST_IDLE), k_q <= n_q)
  `STMA_ASSERT_NEXT(a_merge_start, s_acc && (in_kind == KIND_MERGE), (state_q == ST_READ) && !pass_emit_q)
  `STMA_ASSERT_HOLDS(a_empty_last, m_valid_q && out_empty_q, out_last_q && (out_cnt_q == '0))

endmodule
